FILE: design/btbp_pkg.sv
// ----------------------------------------------------------------------------
// btbp_pkg
// Shared constants and types for the two-level branch predictor with BTB.
// ----------------------------------------------------------------------------
package btbp_pkg;

    // default sizing
    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_MAX_HIST    = 8;

    // fixed field widths
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 30;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES = 3'd0,
        CFG_HIST    = 3'd1,
        CFG_TAG     = 3'd2,
        CFG_INIT    = 3'd3,
        CFG_GHIST   = 3'd4,
        CFG_GTABLE  = 3'd5,
        CFG_SHARE   = 3'd6
    } cfg_idx_t;

    // history/pc xor modes
    localparam logic [1:0] SHARE_NONE = 2'd0;
    localparam logic [1:0] SHARE_PC2  = 2'd1;
    localparam logic [1:0] SHARE_PC16 = 2'd2;

    // action codes
    localparam logic ACT_PREDICT = 1'b0;
    localparam logic ACT_UPDATE  = 1'b1;

endpackage

FILE: design/btb_two_level_branch_predictor_core.sv
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_core
// Direct-mapped BTB with a two-level (local/global, optional gshare) predictor.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the accepting edge until the result.
// A predict that misses the BTB ends in S_LOOK; one that hits passes S_CRD and
// S_PRED; an update passes S_CRD and S_UWR, and one that replaces a valid entry
// with per-entry counter tables also passes S_ROW to re-initialize that entry's
// row in the counter memory. After reset and after every write to registers 0
// to 6, the whole counter memory (2**(SW+MAX_HIST) entries, one per cycle) is
// set to counter_init while busy is high. The result appears for exactly one
// cycle with done; the receiver cannot stall it, so it must be taken then.
// Entry data and counters each live in one RAM with registered read.
module btb_two_level_branch_predictor_core
    import btbp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_HIST    = DEF_MAX_HIST
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command
    input  logic                  start,
    output logic                  busy,
    output logic                  done,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // item
    input  logic                  action,
    input  logic [ADDR_W-1:0]     pc,
    input  logic [ADDR_W-1:0]     target_pc,
    input  logic                  actual_taken,
    input  logic [ADDR_W-1:0]     predicted_dest,
    // result
    output logic                  predict_taken,
    output logic [ADDR_W-1:0]     predict_target,
    output logic [31:0]           branch_count,
    output logic [31:0]           flush_count
);

    localparam int SW        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CAW       = SW + MAX_HIST;
    localparam int CNT_DEPTH = 1 << CAW;
    localparam int ENT_W     = TAG_W + ADDR_W + MAX_HIST;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_LOOK, S_ROW, S_CRD, S_PRED, S_UWR
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [5:0] btb_entries_reg;
    logic [3:0] history_bits_reg;
    logic [4:0] tag_bits_reg;
    logic [1:0] counter_init_reg;
    logic       global_history_reg;
    logic       global_table_reg;
    logic [1:0] share_mode_reg;

    // predictor state
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_HIST-1:0]    shared_hist_reg;
    logic [31:0]            branches_reg;
    logic [31:0]            flushes_reg;

    // item registers
    logic              action_reg;
    logic [ADDR_W-1:0] pc_reg;
    logic [ADDR_W-1:0] target_reg;
    logic              taken_reg;
    logic [ADDR_W-1:0] pred_reg;
    logic [SW-1:0]     slot_reg;
    logic [MAX_HIST-1:0] hist_reg;
    logic [ADDR_W-1:0] ent_target_reg;
    logic [CAW-1:0]    sweep_reg;
    logic [MAX_HIST-1:0] row_reg;

    // result registers
    logic              done_reg;
    logic              ptaken_reg;
    logic [ADDR_W-1:0] ptarget_reg;

    // derived configuration
    logic [8:0]          ent_clamp;
    logic [3:0]          ent_log;
    logic [SW-1:0]       slot_mask;
    logic [3:0]          hist_len;
    logic [MAX_HIST-1:0] hist_mask;
    logic [4:0]          tag_len;
    logic [TAG_W-1:0]    tag_mask;

    always_comb
    begin
        ent_clamp = {3'b000, btb_entries_reg};
        if (ent_clamp == 9'd0)
        begin
            ent_clamp = 9'd1;
        end
        if (ent_clamp > 9'(MAX_ENTRIES))
        begin
            ent_clamp = 9'(MAX_ENTRIES);
        end
        ent_log = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (ent_clamp[i])
            begin
                ent_log = 4'(i);
            end
        end
        for (int i = 0; i < SW; i++)
        begin
            slot_mask[i] = (i < int'(ent_log));
        end

        hist_len = history_bits_reg;
        if (hist_len == 4'd0)
        begin
            hist_len = 4'd1;
        end
        if (hist_len > 4'(MAX_HIST))
        begin
            hist_len = 4'(MAX_HIST);
        end
        for (int i = 0; i < MAX_HIST; i++)
        begin
            hist_mask[i] = (i < int'(hist_len));
        end

        tag_len = (tag_bits_reg > 5'd30) ? 5'd30 : tag_bits_reg;
        for (int i = 0; i < TAG_W; i++)
        begin
            tag_mask[i] = (i < int'(tag_len));
        end
    end

    // index of the incoming pc, tag of the held pc
    logic [SW-1:0]     in_slot;
    logic [ADDR_W-1:0] pc_shift;
    logic [TAG_W-1:0]  cur_tag;

    assign in_slot  = pc[2 +: SW] & slot_mask;
    assign pc_shift = pc_reg >> (6'd2 + {2'b00, ent_log});
    assign cur_tag  = pc_shift[TAG_W-1:0] & tag_mask;

    // entry RAM: {tag, target, local history}
    logic             ent_we;
    logic [ENT_W-1:0] ent_wdata;
    logic [ENT_W-1:0] ent_rdata;
    logic [TAG_W-1:0] ent_tag;
    logic [MAX_HIST-1:0] ent_hist;

    assign ent_tag  = ent_rdata[ENT_W-1 -: TAG_W];
    assign ent_hist = ent_rdata[MAX_HIST-1:0];

    btbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (slot_reg),
        .wdata (ent_wdata),
        .raddr (in_slot),
        .rdata (ent_rdata)
    );

    // counter address from the held history
    logic [MAX_HIST-1:0] share_bits;
    logic [MAX_HIST-1:0] cnt_idx;
    logic [CAW-1:0]      cnt_addr;

    always_comb
    begin
        case (share_mode_reg)
            SHARE_PC2:  share_bits = pc_reg[2 +: MAX_HIST];
            SHARE_PC16: share_bits = pc_reg[16 +: MAX_HIST];
            default:    share_bits = '0;
        endcase
        cnt_idx  = (hist_reg ^ share_bits) & hist_mask;
        cnt_addr = global_table_reg ? {{SW{1'b0}}, cnt_idx} : {slot_reg, cnt_idx};
    end

    // counter RAM port mux
    logic           cnt_we;
    logic [CAW-1:0] cnt_waddr;
    logic [1:0]     cnt_wdata;
    logic [1:0]     cnt_rdata;
    logic [1:0]     cnt_new;

    always_comb
    begin
        cnt_new = cnt_rdata;
        if (taken_reg)
        begin
            if (cnt_rdata != 2'd3)
            begin
                cnt_new = cnt_rdata + 2'd1;
            end
        end
        else if (cnt_rdata != 2'd0)
        begin
            cnt_new = cnt_rdata - 2'd1;
        end

        case (state_reg)
            S_INIT:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_reg;
                cnt_wdata = counter_init_reg;
            end
            S_ROW:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = {slot_reg, row_reg};
                cnt_wdata = counter_init_reg;
            end
            S_UWR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = cnt_addr;
                cnt_wdata = cnt_new;
            end
            default:
            begin
                cnt_we    = 1'b0;
                cnt_waddr = cnt_addr;
                cnt_wdata = cnt_new;
            end
        endcase
    end

    btbp_ram #(
        .WIDTH (2),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_addr),
        .rdata (cnt_rdata)
    );

    // update write-back values
    logic [MAX_HIST-1:0] hist_new;
    logic                mispredict;

    assign hist_new   = ((hist_reg << 1) | MAX_HIST'(taken_reg)) & hist_mask;
    assign mispredict = taken_reg ? (target_reg != pred_reg)
                                  : (pred_reg != (pc_reg + 32'd4));
    assign ent_we     = (state_reg == S_UWR);
    assign ent_wdata  = {cur_tag, target_reg, hist_new};

    // lookup decode
    logic entry_vld;
    logic tag_hit;

    assign entry_vld = valid_reg[slot_reg];
    assign tag_hit   = (ent_tag == cur_tag);

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_INIT;
            btb_entries_reg    <= 6'd1;
            history_bits_reg   <= 4'd1;
            tag_bits_reg       <= 5'd0;
            counter_init_reg   <= 2'd1;
            global_history_reg <= 1'b0;
            global_table_reg   <= 1'b0;
            share_mode_reg     <= SHARE_NONE;
            valid_reg          <= '0;
            shared_hist_reg    <= '0;
            branches_reg       <= '0;
            flushes_reg        <= '0;
            sweep_reg          <= '0;
            row_reg            <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == CAW'(CNT_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    row_reg <= '0;
                    if (action_reg == ACT_PREDICT)
                    begin
                        if (entry_vld && tag_hit)
                        begin
                            state_reg <= S_CRD;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                            done_reg  <= 1'b1;
                        end
                    end
                    else if (entry_vld && !tag_hit && !global_table_reg)
                    begin
                        state_reg <= S_ROW;
                    end
                    else
                    begin
                        state_reg <= S_CRD;
                    end
                end
                S_ROW:
                begin
                    row_reg <= row_reg + 1'b1;
                    if (row_reg == '1)
                    begin
                        state_reg <= S_CRD;
                    end
                end
                S_CRD:
                begin
                    state_reg <= (action_reg == ACT_PREDICT) ? S_PRED : S_UWR;
                end
                S_PRED:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                S_UWR:
                begin
                    state_reg           <= S_IDLE;
                    done_reg            <= 1'b1;
                    valid_reg[slot_reg] <= 1'b1;
                    branches_reg        <= branches_reg + 32'd1;
                    if (mispredict)
                    begin
                        flushes_reg <= flushes_reg + 32'd1;
                    end
                    if (global_history_reg)
                    begin
                        shared_hist_reg <= hist_new;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // a write to registers 0 to 6 re-initializes the predictor
            if (cfg_we && (cfg_index <= CFG_SHARE))
            begin
                state_reg       <= S_INIT;
                sweep_reg       <= '0;
                valid_reg       <= '0;
                shared_hist_reg <= '0;
                branches_reg    <= '0;
                flushes_reg     <= '0;
                done_reg        <= 1'b0;
                case (cfg_idx_t'(cfg_index))
                    CFG_ENTRIES: btb_entries_reg    <= cfg_data;
                    CFG_HIST:    history_bits_reg   <= cfg_data[3:0];
                    CFG_TAG:     tag_bits_reg       <= cfg_data[4:0];
                    CFG_INIT:    counter_init_reg   <= cfg_data[1:0];
                    CFG_GHIST:   global_history_reg <= cfg_data[0];
                    CFG_GTABLE:  global_table_reg   <= cfg_data[0];
                    CFG_SHARE:   share_mode_reg     <= cfg_data[1:0];
                    default:     btb_entries_reg    <= btb_entries_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            action_reg <= action;
            pc_reg     <= pc;
            target_reg <= target_pc;
            taken_reg  <= actual_taken;
            pred_reg   <= predicted_dest;
            slot_reg   <= in_slot;
        end
        if (state_reg == S_LOOK)
        begin
            ent_target_reg <= ent_rdata[MAX_HIST +: ADDR_W];
            if (global_history_reg)
            begin
                hist_reg <= shared_hist_reg;
            end
            else if (entry_vld && tag_hit)
            begin
                hist_reg <= ent_hist;
            end
            else
            begin
                hist_reg <= '0;
            end
            ptaken_reg  <= 1'b0;
            ptarget_reg <= (action_reg == ACT_PREDICT) ? (pc_reg + 32'd4) : '0;
        end
        if (state_reg == S_PRED && cnt_rdata[1])
        begin
            ptaken_reg  <= 1'b1;
            ptarget_reg <= ent_target_reg;
        end
        if (state_reg == S_UWR)
        begin
            ptaken_reg  <= 1'b0;
            ptarget_reg <= '0;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign predict_taken  = ptaken_reg;
    assign predict_target = ptarget_reg;
    assign branch_count   = branches_reg;
    assign flush_count    = flushes_reg;

endmodule

FILE: design/btbp_ram.sv
// ----------------------------------------------------------------------------
// btbp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module btbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/btbp_checker.sv
// ----------------------------------------------------------------------------
// btbp_checker
// Port-level checks for the branch predictor core, bound to the top level.
// ----------------------------------------------------------------------------
module btbp_checker
    import btbp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic                 predict_taken
);

    // an accepted command always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !cfg_we |=> busy)
        else $error("accepted transfer did not raise busy");

    // the result comes with the block free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // a register write starts the clearing pass
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index <= CFG_SHARE) |=> busy && !done)
        else $error("register write did not start re-initialization");

    // nothing is predicted taken while the block is clearing
    a_taken_done: assert property (@(posedge clk) disable iff (!rst_n)
        done && predict_taken |-> !$past(cfg_we))
        else $error("taken prediction right after a register write");

endmodule

bind btb_two_level_branch_predictor_core btbp_checker u_btbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .predict_taken (predict_taken)
);

FILE: sim/btb_two_level_branch_predictor_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btb_two_level_branch_predictor_core_tb
// Self-checking bench for the BTB with two-level direction predictor. A local
// predictor tracks entries, histories, counters and statistics. Each result
// strobe is compared with the oldest predicted result. The run covers
// directed corner items, register extremes and random predict/update pairs
// under several settings and sender idle rates.
// ----------------------------------------------------------------------------
module btb_two_level_branch_predictor_core_tb;
    import btbp_pkg::*;

    localparam int NUM_SLOTS  = 32;
    localparam int ROW_SIZE   = 256;
    localparam int CYCLE_MAX  = 2000000;

    typedef struct {
        logic        action;
        logic [31:0] pc;
        logic [31:0] target_pc;
        logic        actual_taken;
        logic [31:0] predicted_dest;
    } branch_item_t;

    typedef struct {
        logic        predict_taken;
        logic [31:0] predict_target;
        logic [31:0] branch_count;
        logic [31:0] flush_count;
    } branch_result_t;

    // DUT signals
    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  done;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  action;
    logic [ADDR_W-1:0]     pc;
    logic [ADDR_W-1:0]     target_pc;
    logic                  actual_taken;
    logic [ADDR_W-1:0]     predicted_dest;
    logic                  predict_taken;
    logic [ADDR_W-1:0]     predict_target;
    logic [31:0]           branch_count;
    logic [31:0]           flush_count;

    // predictor registers and state
    logic [5:0]  reg_entries;
    logic [3:0]  reg_hist;
    logic [4:0]  reg_tag;
    logic [1:0]  reg_init;
    logic        reg_ghist;
    logic        reg_gtable;
    logic [1:0]  reg_share;
    int unsigned eff_entries, eff_log, eff_hist, eff_tag;
    logic        slot_valid [NUM_SLOTS];
    logic [31:0] slot_tag [NUM_SLOTS];
    logic [31:0] slot_target [NUM_SLOTS];
    logic [7:0]  slot_hist [NUM_SLOTS];
    logic [7:0]  shared_hist;
    logic [1:0]  ctr_mem [NUM_SLOTS*ROW_SIZE];
    logic [31:0] branches_seen, mispredicts_seen;

    branch_result_t pending_results[$];
    int          err_count;
    int          cycle_count;
    int          idle_pct;
    logic [31:0] pc_pool [12];

    btb_two_level_branch_predictor_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .action         (action),
        .pc             (pc),
        .target_pc      (target_pc),
        .actual_taken   (actual_taken),
        .predicted_dest (predicted_dest),
        .predict_taken  (predict_taken),
        .predict_target (predict_target),
        .branch_count   (branch_count),
        .flush_count    (flush_count)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    // derive effective sizes and clear all state
    function automatic void predictor_clear();
        int unsigned v;
        v = reg_entries;
        if (v < 1) v = 1;
        if (v > NUM_SLOTS) v = NUM_SLOTS;
        eff_entries = 1;
        eff_log = 0;
        while (eff_entries * 2 <= v)
        begin
            eff_entries = eff_entries * 2;
            eff_log++;
        end
        eff_hist = reg_hist;
        if (eff_hist < 1) eff_hist = 1;
        if (eff_hist > 8) eff_hist = 8;
        eff_tag = (reg_tag > 30) ? 30 : reg_tag;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_tag[i] = '0;
            slot_target[i] = '0;
            slot_hist[i] = '0;
        end
        for (int i = 0; i < NUM_SLOTS*ROW_SIZE; i++)
            ctr_mem[i] = reg_init;
        shared_hist = '0;
        branches_seen = '0;
        mispredicts_seen = '0;
    endfunction

    function automatic void predictor_write(cfg_idx_t idx, logic [5:0] v);
        case (idx)
            CFG_ENTRIES: reg_entries = v;
            CFG_HIST:    reg_hist = v[3:0];
            CFG_TAG:     reg_tag = v[4:0];
            CFG_INIT:    reg_init = v[1:0];
            CFG_GHIST:   reg_ghist = v[0];
            CFG_GTABLE:  reg_gtable = v[0];
            CFG_SHARE:   reg_share = v[1:0];
            default:     return;
        endcase
        predictor_clear();
    endfunction

    // counter address from history, optional pc xor, table mode
    function automatic int unsigned ctr_addr(int unsigned slot, logic [31:0] bpc);
        logic [31:0] h;
        h = 32'(reg_ghist ? shared_hist : slot_hist[slot]);
        if (reg_share == SHARE_PC2) h = h ^ (bpc >> 2);
        else if (reg_share == SHARE_PC16) h = h ^ (bpc >> 16);
        h = h & ((32'd1 << eff_hist) - 1);
        return reg_gtable ? h : slot * ROW_SIZE + h;
    endfunction

    // expected result of one item; advances the predictor state
    function automatic branch_result_t branch_outcome(branch_item_t it);
        int unsigned    slot, addr;
        logic [31:0]    tg, h;
        branch_result_t r;
        slot = (it.pc >> 2) & (eff_entries - 1);
        tg = (it.pc >> (2 + eff_log)) & ((32'd1 << eff_tag) - 1);
        if (it.action == ACT_PREDICT)
        begin
            r.predict_taken = 1'b0;
            r.predict_target = it.pc + 32'd4;
            if (slot_valid[slot] && slot_tag[slot] == tg)
            begin
                if (ctr_mem[ctr_addr(slot, it.pc)] >= 2)
                begin
                    r.predict_taken = 1'b1;
                    r.predict_target = slot_target[slot];
                end
            end
            r.branch_count = branches_seen;
            r.flush_count = mispredicts_seen;
            return r;
        end
        branches_seen++;
        // allocate or replace the entry
        if (slot_valid[slot])
        begin
            if (slot_tag[slot] != tg)
            begin
                if (!reg_ghist) slot_hist[slot] = '0;
                if (!reg_gtable)
                    for (int i = 0; i < ROW_SIZE; i++)
                        ctr_mem[slot*ROW_SIZE + i] = reg_init;
                slot_tag[slot] = tg;
            end
        end
        else
        begin
            slot_tag[slot] = tg;
            slot_valid[slot] = 1'b1;
        end
        if (it.actual_taken && it.target_pc != it.predicted_dest) mispredicts_seen++;
        if (!it.actual_taken && it.predicted_dest != it.pc + 32'd4) mispredicts_seen++;
        // train counter and shift history
        addr = ctr_addr(slot, it.pc);
        h = 32'(reg_ghist ? shared_hist : slot_hist[slot]);
        h = ((h << 1) | 32'(it.actual_taken)) & ((32'd1 << eff_hist) - 1);
        if (reg_ghist) shared_hist = h[7:0];
        else slot_hist[slot] = h[7:0];
        if (it.actual_taken)
        begin
            if (ctr_mem[addr] < 3) ctr_mem[addr]++;
        end
        else if (ctr_mem[addr] > 0)
            ctr_mem[addr]--;
        slot_target[slot] = it.target_pc;
        r.predict_taken = 1'b0;
        r.predict_target = '0;
        r.branch_count = branches_seen;
        r.flush_count = mispredicts_seen;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        branch_result_t w;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result transfer", 32'd0, 32'd0);
            else
            begin
                w = pending_results.pop_front();
                if (predict_taken !== w.predict_taken)
                    report_mismatch("predict_taken", 32'(predict_taken),
                                    32'(w.predict_taken));
                if (predict_target !== w.predict_target)
                    report_mismatch("predict_target", predict_target, w.predict_target);
                if (branch_count !== w.branch_count)
                    report_mismatch("branch_count", branch_count, w.branch_count);
                if (flush_count !== w.flush_count)
                    report_mismatch("flush_count", flush_count, w.flush_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers (called at a falling edge, return at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_branch(branch_item_t it, output branch_result_t r);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        action = it.action;
        pc = it.pc;
        target_pc = it.target_pc;
        actual_taken = it.actual_taken;
        predicted_dest = it.predicted_dest;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        r = branch_outcome(it);
        pending_results.push_back(r);
        @(negedge clk);
    endtask

    task automatic send_fields(logic act, logic [31:0] bpc, logic [31:0] tgt,
                               logic tk, logic [31:0] pd);
        branch_item_t   it;
        branch_result_t r;
        it.action = act;
        it.pc = bpc;
        it.target_pc = tgt;
        it.actual_taken = tk;
        it.predicted_dest = pd;
        send_branch(it, r);
    endtask

    // wait until every transfer has come back and the block is free
    task automatic drain();
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [5:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        predictor_write(idx, v);
        @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task automatic set_all(logic [5:0] ent, logic [5:0] hb, logic [5:0] tb,
                           logic [5:0] ci, logic [5:0] gh, logic [5:0] gt,
                           logic [5:0] sh);
        write_reg(CFG_ENTRIES, ent);
        write_reg(CFG_HIST, hb);
        write_reg(CFG_TAG, tb);
        write_reg(CFG_INIT, ci);
        write_reg(CFG_GHIST, gh);
        write_reg(CFG_GTABLE, gt);
        write_reg(CFG_SHARE, sh);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset settings: one entry, no tag; wrap of pc+4 and both mispredict kinds
    task automatic test_reset_defaults();
        idle_pct = 0;
        send_fields(ACT_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0);
        send_fields(ACT_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_fields(ACT_PREDICT, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0);
        send_fields(ACT_UPDATE, 32'hFFFF_FFFC, 32'h1234_5678, 1'b1, 32'h0);
        send_fields(ACT_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0);
        send_fields(ACT_UPDATE, 32'hFFFF_FFFC, 32'h0, 1'b0, 32'h0000_0000);
        send_fields(ACT_UPDATE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b0, 32'h0000_0004);
        send_fields(ACT_PREDICT, 32'h0000_0003, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    endtask

    // register extremes, clamping and share mode three, tag replacement
    task automatic test_register_extremes();
        set_all(6'd63, 6'd15, 6'd31, 6'd3, 6'd0, 6'd0, 6'd3);
        send_fields(ACT_UPDATE, 32'h8000_0010, 32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA);
        send_fields(ACT_PREDICT, 32'h8000_0010, 32'h0, 1'b0, 32'h0);
        send_fields(ACT_UPDATE, 32'h4000_0010, 32'h5555_5555, 1'b0, 32'h4000_0014);
        send_fields(ACT_PREDICT, 32'h4000_0010, 32'h0, 1'b0, 32'h0);
        send_fields(ACT_PREDICT, 32'h8000_0010, 32'h0, 1'b0, 32'h0);
        set_all(6'd0, 6'd0, 6'd30, 6'd0, 6'd1, 6'd1, 6'd2);
        send_fields(ACT_UPDATE, 32'h0001_0000, 32'h0000_1000, 1'b1, 32'h0);
        send_fields(ACT_UPDATE, 32'h0001_0000, 32'h0000_1000, 1'b1, 32'h0000_1000);
        send_fields(ACT_PREDICT, 32'h0001_0000, 32'h0, 1'b0, 32'h0);
        send_fields(ACT_PREDICT, 32'h0003_0000, 32'h0, 1'b0, 32'h0);
        set_all(6'd32, 6'd8, 6'd0, 6'd2, 6'd0, 6'd1, 6'd1);
        send_fields(ACT_PREDICT, 32'h0000_007C, 32'h0, 1'b0, 32'h0);
        send_fields(ACT_UPDATE, 32'h0000_007C, 32'h0BAD_F00D, 1'b0, 32'h0000_0080);
        send_fields(ACT_PREDICT, 32'h0000_007C, 32'h0, 1'b0, 32'h0);
    endtask

    // random predict/update pairs over a small pool of colliding pcs
    task automatic test_random_traffic(int pairs, int idle);
        branch_item_t   it;
        branch_result_t r;
        idle_pct = idle;
        for (int i = 0; i < 12; i++)
        begin
            pc_pool[i] = $urandom;
            pc_pool[i][6:2] = 5'($urandom_range(0, 7));
        end
        for (int k = 0; k < pairs; k++)
        begin
            it.pc = ($urandom_range(99) < 85) ? pc_pool[$urandom_range(0, 11)] : $urandom;
            if ($urandom_range(99) < 20)
            begin
                // noise: any fields at all
                it.action = 1'($urandom);
                it.target_pc = $urandom;
                it.actual_taken = 1'($urandom);
                it.predicted_dest = $urandom;
                send_branch(it, r);
            end
            else
            begin
                it.action = ACT_PREDICT;
                it.target_pc = $urandom;
                it.actual_taken = 1'($urandom);
                it.predicted_dest = $urandom;
                send_branch(it, r);
                it.action = ACT_UPDATE;
                it.actual_taken = ($urandom_range(99) < 70);
                it.target_pc = ($urandom_range(99) < 70) ? (it.pc ^ 32'h0000_0F00) : $urandom;
                it.predicted_dest = ($urandom_range(99) < 75) ? r.predict_target : $urandom;
                send_branch(it, r);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ENTRIES;
        cfg_data = '0;
        action = ACT_PREDICT;
        pc = '0;
        target_pc = '0;
        actual_taken = 1'b0;
        predicted_dest = '0;
        err_count = 0;
        cycle_count = 0;
        idle_pct = 0;
        reg_entries = 6'd1;
        reg_hist = 4'd1;
        reg_tag = 5'd0;
        reg_init = 2'd1;
        reg_ghist = 1'b0;
        reg_gtable = 1'b0;
        reg_share = SHARE_NONE;
        predictor_clear();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        while (busy) @(negedge clk);

        test_reset_defaults();
        test_register_extremes();
        set_all(6'd32, 6'd8, 6'd4, 6'd0, 6'd0, 6'd0, 6'd1);
        test_random_traffic(60, 0);
        set_all(6'd8, 6'd3, 6'd2, 6'd2, 6'd1, 6'd0, 6'd2);
        test_random_traffic(60, 65);
        set_all(6'd16, 6'd5, 6'd30, 6'd3, 6'd0, 6'd1, 6'd0);
        test_random_traffic(60, 12);
        set_all(6'd4, 6'd2, 6'd1, 6'd1, 6'd1, 6'd1, 6'd1);
        test_random_traffic(60, 65);

        drain();
        repeat (20) @(negedge clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
